// ===== src/spcol_pkg.sv =====
// spcol_pkg: shared types, constants and helpers of the sprite collision block
// no dependencies; imported by every module of the block except spcol_ram
package spcol_pkg;

    localparam int SPRITE_COUNT_DEF = 16;
    localparam int SPRITE_W_DEF     = 64;
    localparam int SPRITE_H_DEF     = 64;

    localparam int POS_W   = 16;
    localparam int SCALE_W = 8;
    localparam int MASK_W  = 16;
    localparam int BADDR_W = 11;
    localparam int EDGE_W  = 18;   // box edges in 1/16 pixel
    localparam int PIX_W   = 14;   // whole screen pixels
    localparam int NUM_W   = 18;   // divider numerator, signed
    localparam int MAG_W   = 17;   // numerator magnitude
    localparam int Q_W     = 19;   // local pixel quotient, signed
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_ATTR  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SCALE = 2'd2;

    localparam logic [3:0] NIBBLE_MASK = 4'h0F;

    typedef struct packed {
        logic [1:0]               action;
        logic [7:0]               first_sprite;
        logic [7:0]               second_sprite;
        logic [BADDR_W-1:0]       byte_address;
        logic [7:0]               byte_value;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [SCALE_W-1:0]       scale;
        logic [MASK_W-1:0]        collide_mask;
        logic                     enable_flag;
        logic                     bitmap_present;
    } item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       box_hit;
        logic       pixel_hit;
    } result_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [SCALE_W-1:0]      scale;
        logic [MASK_W-1:0]       mask;
        logic                    en;
        logic                    bm;
    } attr_t;

    typedef enum logic [1:0] {
        CMD_RESULT,
        CMD_BMWRITE,
        CMD_QUERY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [1:0]              status;
        logic                    box_hit;
        logic [7:0]              spr_a;
        logic [7:0]              spr_b;
        logic [BADDR_W-1:0]      baddr;
        logic [7:0]              bval;
        logic signed [POS_W-1:0] xa;
        logic signed [POS_W-1:0] ya;
        logic [SCALE_W-1:0]      sa;
        logic [MASK_W-1:0]       ma;
        logic signed [POS_W-1:0] xb;
        logic signed [POS_W-1:0] yb;
        logic [SCALE_W-1:0]      sb;
        logic [MASK_W-1:0]       mb;
        logic signed [PIX_W-1:0] xs;
        logic signed [PIX_W-1:0] xe;
        logic signed [PIX_W-1:0] ys;
        logic signed [PIX_W-1:0] ye;
    } cmd_t;

    typedef struct packed {
        logic push;
        logic ready;
    } qctl_t;

    typedef enum logic {
        FE_IDLE,
        FE_LOOK
    } fe_state_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIV_START,
        BK_DIV_RUN,
        BK_SETUP,
        BK_PIX,
        BK_RDA,
        BK_RDB,
        BK_CHK,
        BK_DONE
    } bk_state_t;

    // truncate a 1/16 pixel edge toward zero to whole pixels
    function automatic logic signed [PIX_W-1:0] trunc16(input logic signed [EDGE_W-1:0] v);
        logic signed [EDGE_W-1:0] t;
        t = v[EDGE_W-1] ? v + EDGE_W'(15) : v;
        return PIX_W'(t >>> 4);
    endfunction

endpackage

// ===== src/spcol_ram.sv =====
// spcol_ram: generic single write, single read RAM with registered read data
// no dependencies
module spcol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== src/spcol_queue.sv =====
// spcol_queue: short command queue between the front and back ends
// depends on spcol_pkg
module spcol_queue
    import spcol_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  qctl_t in_ctl_i,
    output logic  in_ready,
    input  cmd_t  in_cmd,
    input  logic  pop,
    output logic  out_valid,
    output cmd_t  out_cmd
);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            ent_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_reg, rd_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_push, do_pop;

    assign in_ready  = (cnt_reg != CW'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_cmd   = ent_reg[rd_reg];
    assign do_push   = in_ctl_i.push && in_ready;
    assign do_pop    = pop && out_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                ent_reg[wr_reg] <= in_cmd;
                wr_reg <= (wr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("queue count lost a push");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (wr_reg == rd_reg))
        else $error("queue pointers differ while empty");
endmodule

// ===== src/spcol_front.sv =====
// spcol_front: accepts transactions, keeps the sprite attribute table and classifies items
// depends on spcol_pkg and spcol_ram
module spcol_front
    import spcol_pkg::*;
#(
    parameter int SPRITE_COUNT = SPRITE_COUNT_DEF,
    parameter int SPRITE_W     = SPRITE_W_DEF,
    parameter int SPRITE_H     = SPRITE_H_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_data,
    output qctl_t q_ctl,
    input  logic  q_ready,
    output cmd_t  q_cmd
);
    localparam int SW    = $clog2(SPRITE_COUNT);
    localparam int BYTES = (SPRITE_W * SPRITE_H) / 2;
    localparam int AWID  = $bits(attr_t);

    fe_state_t state_reg, state_next;
    item_t     item_reg;
    logic [SPRITE_COUNT-1:0] vld_reg;

    logic          accept, attr_we;
    logic [SW-1:0] raddr_a, raddr_b;
    attr_t         wattr, ra, rb;
    logic [AWID-1:0] ra_bits, rb_bits;

    assign accept = s_valid && s_ready;
    assign attr_we = accept && (s_data.action == ACT_ATTR)
                     && (9'(s_data.first_sprite) < 9'(SPRITE_COUNT))
                     && (s_data.scale != '0);
    assign wattr = '{x: s_data.pos_x, y: s_data.pos_y, scale: s_data.scale,
                     mask: s_data.collide_mask, en: s_data.enable_flag,
                     bm: s_data.bitmap_present};
    assign raddr_a = (state_reg == FE_IDLE) ? s_data.first_sprite[SW-1:0]
                                            : item_reg.first_sprite[SW-1:0];
    assign raddr_b = (state_reg == FE_IDLE) ? s_data.second_sprite[SW-1:0]
                                            : item_reg.second_sprite[SW-1:0];

    // two copies so both sprites of a pair are read in the same cycle
    spcol_ram #(.WIDTH(AWID), .DEPTH(SPRITE_COUNT)) u_attr_a (
        .aclk(aclk), .we(attr_we), .waddr(s_data.first_sprite[SW-1:0]),
        .wdata(wattr), .raddr(raddr_a), .rdata(ra_bits));
    spcol_ram #(.WIDTH(AWID), .DEPTH(SPRITE_COUNT)) u_attr_b (
        .aclk(aclk), .we(attr_we), .waddr(s_data.first_sprite[SW-1:0]),
        .wdata(wattr), .raddr(raddr_b), .rdata(rb_bits));
    assign ra = attr_t'(ra_bits);
    assign rb = attr_t'(rb_bits);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FE_IDLE;
            vld_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (attr_we) begin
                vld_reg[s_data.first_sprite[SW-1:0]] <= 1'b1;
            end
        end
        if (accept) begin
            item_reg <= s_data;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FE_IDLE: if (s_valid) state_next = FE_LOOK;
            FE_LOOK: if (q_ready) state_next = FE_IDLE;
            default: state_next = FE_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = (state_reg == FE_IDLE);
        q_ctl.push = (state_reg == FE_LOOK);
        q_ctl.ready = q_ready;
    end

    // classification
    logic ok_a, ok_b, elig_a, elig_b, overlap;
    logic signed [EDGE_W-1:0] l1, r1, t1, b1, l2, r2, t2, b2, wa, ha, wb, hb;
    logic signed [EDGE_W-1:0] ol, orr, ot, ob;

    always_comb begin
        ok_a = 9'(item_reg.first_sprite) < 9'(SPRITE_COUNT);
        ok_b = 9'(item_reg.second_sprite) < 9'(SPRITE_COUNT);
        elig_a = vld_reg[item_reg.first_sprite[SW-1:0]] && ra.en && ra.bm && (ra.mask != '0);
        elig_b = vld_reg[item_reg.second_sprite[SW-1:0]] && rb.en && rb.bm && (rb.mask != '0);
        wa = EDGE_W'(SPRITE_W) * EDGE_W'(ra.scale);
        ha = EDGE_W'(SPRITE_H) * EDGE_W'(ra.scale);
        wb = EDGE_W'(SPRITE_W) * EDGE_W'(rb.scale);
        hb = EDGE_W'(SPRITE_H) * EDGE_W'(rb.scale);
        l1 = EDGE_W'(ra.x);
        t1 = EDGE_W'(ra.y);
        r1 = l1 + wa;
        b1 = t1 + ha;
        l2 = EDGE_W'(rb.x);
        t2 = EDGE_W'(rb.y);
        r2 = l2 + wb;
        b2 = t2 + hb;
        overlap = !(l1 >= r2 || r1 <= l2 || t1 >= b2 || b1 <= t2);
        ol  = (l1 > l2) ? l1 : l2;
        ot  = (t1 > t2) ? t1 : t2;
        orr = (r1 < r2) ? r1 : r2;
        ob  = (b1 < b2) ? b1 : b2;

        q_cmd = '{kind: CMD_RESULT, status: ST_OK, box_hit: 1'b0,
                  spr_a: item_reg.first_sprite, spr_b: item_reg.second_sprite,
                  baddr: item_reg.byte_address, bval: item_reg.byte_value,
                  xa: ra.x, ya: ra.y, sa: ra.scale, ma: ra.mask,
                  xb: rb.x, yb: rb.y, sb: rb.scale, mb: rb.mask,
                  xs: trunc16(ol), xe: trunc16(orr), ys: trunc16(ot), ye: trunc16(ob)};
        case (item_reg.action)
            ACT_BYTE: begin
                if (!ok_a) begin
                    q_cmd.status = ST_RANGE;
                end else if (int'(item_reg.byte_address) < BYTES) begin
                    q_cmd.kind = CMD_BMWRITE;
                end
            end
            ACT_ATTR: begin
                if (!ok_a) begin
                    q_cmd.status = ST_RANGE;
                end else if (item_reg.scale == '0) begin
                    q_cmd.status = ST_SCALE;
                end
            end
            ACT_QUERY: begin
                if (!(ok_a && ok_b)) begin
                    q_cmd.status = ST_RANGE;
                end else if (elig_a && elig_b && overlap) begin
                    q_cmd.kind    = CMD_QUERY;
                    q_cmd.box_hit = 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule

// ===== src/spcol_div.sv =====
// spcol_div: iterative floor division of a signed numerator by an 8-bit scale
// depends on spcol_pkg
module spcol_div
    import spcol_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [NUM_W-1:0]   num,
    input  logic [SCALE_W-1:0]        den,
    output logic                      done,
    output logic signed [Q_W-1:0]     quo,
    output logic [SCALE_W-1:0]        rem
);
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic                 busy_reg, done_reg, neg_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [MAG_W-1:0]     mag_reg;
    logic [SCALE_W-1:0]   rem_reg, den_reg;
    logic [SCALE_W:0]     trial;
    logic                 ge;
    logic signed [Q_W-1:0] qpos;
    logic signed [NUM_W-1:0] absn;

    assign absn  = num[NUM_W-1] ? -num : num;
    assign trial = {rem_reg, mag_reg[MAG_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MAG_W);
                neg_reg  <= num[NUM_W-1];
                mag_reg  <= MAG_W'(absn);
                den_reg  <= den;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= ge ? SCALE_W'(trial - {1'b0, den_reg}) : SCALE_W'(trial);
                mag_reg <= {mag_reg[MAG_W-2:0], ge};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // convert magnitude result to floor quotient and nonnegative remainder
    always_comb begin
        qpos = Q_W'(mag_reg);
        if (neg_reg && rem_reg != '0) begin
            quo = -(qpos + Q_W'(1));
            rem = den_reg - rem_reg;
        end else begin
            quo = neg_reg ? -qpos : qpos;
            rem = rem_reg;
        end
    end

    assign done = done_reg;
endmodule

// ===== src/spcol_back.sv =====
// spcol_back: executes queued commands, holds the bitmap store and scans overlaps
// depends on spcol_pkg, spcol_ram and spcol_div
module spcol_back
    import spcol_pkg::*;
#(
    parameter int SPRITE_COUNT = SPRITE_COUNT_DEF,
    parameter int SPRITE_W     = SPRITE_W_DEF,
    parameter int SPRITE_H     = SPRITE_H_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    input  cmd_t    q_cmd,
    output logic    q_pop,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);
    localparam int BYTES = (SPRITE_W * SPRITE_H) / 2;
    localparam int DEPTH = SPRITE_COUNT * BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int IDX_W = $clog2(SPRITE_W * SPRITE_H);
    localparam int LX_W  = $clog2(SPRITE_W);
    localparam int LY_W  = $clog2(SPRITE_H);

    bk_state_t state_reg, state_next;
    cmd_t      cmd_reg;
    logic [2:0] sel_reg;
    logic [4:0]          k_reg  [2];
    logic [SCALE_W-1:0]  m_reg  [2];
    logic signed [Q_W-1:0] qx0_reg [2], qx_reg [2], qy_reg [2];
    logic [SCALE_W-1:0]  rx0_reg [2], rx_reg [2], ry_reg [2];
    logic signed [PIX_W-1:0] sx_reg, sy_reg;
    logic [AW-1:0]       addr_reg [2];
    logic                lsb_reg  [2];
    logic [3:0]          col_a_reg;
    logic                hit_reg;
    logic                mv_reg;
    result_t             md_reg;

    logic out_free, out_load, ram_we, div_start, div_done;
    result_t out_data;
    logic [AW-1:0] waddr, raddr;
    logic [7:0] rdata;
    logic signed [NUM_W-1:0] div_num;
    logic [SCALE_W-1:0] div_den, div_rem;
    logic signed [Q_W-1:0] div_quo;

    logic [SCALE_W-1:0] den [2];
    logic [MASK_W-1:0]  msk [2];
    logic [7:0]         spr [2];
    logic signed [Q_W-1:0] tx [2], ty [2];
    logic                in_box [2];
    logic [AW-1:0]       addr_c [2];
    logic signed [Q_W-1:0] qx_st [2], qy_st [2];
    logic [SCALE_W-1:0]  rx_st [2], ry_st [2];
    logic [3:0]          col_b;
    logic                hit, x_more, y_more, last, empty;

    assign out_free = !mv_reg || m_ready;
    assign waddr = AW'(q_cmd.spr_a) * AW'(BYTES) + AW'(q_cmd.baddr);
    assign raddr = (state_reg == BK_RDA) ? addr_reg[0] : addr_reg[1];

    spcol_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_bitmap (
        .aclk(aclk), .we(ram_we), .waddr(waddr), .wdata(q_cmd.bval),
        .raddr(raddr), .rdata(rdata));

    // divisions in order: 16/s, row start x, start y, sprite a then sprite b
    always_comb begin
        div_den = (sel_reg < 3'd3) ? cmd_reg.sa : cmd_reg.sb;
        case (sel_reg)
            3'd1: div_num = (NUM_W'(cmd_reg.xs) <<< 4) - NUM_W'(cmd_reg.xa);
            3'd2: div_num = (NUM_W'(cmd_reg.ys) <<< 4) - NUM_W'(cmd_reg.ya);
            3'd4: div_num = (NUM_W'(cmd_reg.xs) <<< 4) - NUM_W'(cmd_reg.xb);
            3'd5: div_num = (NUM_W'(cmd_reg.ys) <<< 4) - NUM_W'(cmd_reg.yb);
            default: div_num = NUM_W'(16);
        endcase
    end

    spcol_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num),
        .den(div_den), .done(div_done), .quo(div_quo), .rem(div_rem));

    always_comb begin
        den[0] = cmd_reg.sa;  den[1] = cmd_reg.sb;
        msk[0] = cmd_reg.ma;  msk[1] = cmd_reg.mb;
        spr[0] = cmd_reg.spr_a; spr[1] = cmd_reg.spr_b;
        for (int l = 0; l < 2; l++) begin
            tx[l] = (qx_reg[l] < 0 && rx_reg[l] != '0) ? qx_reg[l] + Q_W'(1) : qx_reg[l];
            ty[l] = (qy_reg[l] < 0 && ry_reg[l] != '0) ? qy_reg[l] + Q_W'(1) : qy_reg[l];
            in_box[l] = (tx[l] >= 0) && (tx[l] < Q_W'(SPRITE_W))
                        && (ty[l] >= 0) && (ty[l] < Q_W'(SPRITE_H));
            addr_c[l] = AW'(spr[l]) * AW'(BYTES)
                        + AW'((IDX_W'(ty[l][LY_W-1:0]) * IDX_W'(SPRITE_W)
                               + IDX_W'(tx[l][LX_W-1:0])) >> 1);
            // one pixel step: add 16/s as quotient and remainder
            qx_st[l] = qx_reg[l] + Q_W'(k_reg[l])
                       + Q_W'(({1'b0, rx_reg[l]} + {1'b0, m_reg[l]}) >= {1'b0, den[l]});
            rx_st[l] = (({1'b0, rx_reg[l]} + {1'b0, m_reg[l]}) >= {1'b0, den[l]})
                       ? rx_reg[l] + m_reg[l] - den[l] : rx_reg[l] + m_reg[l];
            qy_st[l] = qy_reg[l] + Q_W'(k_reg[l])
                       + Q_W'(({1'b0, ry_reg[l]} + {1'b0, m_reg[l]}) >= {1'b0, den[l]});
            ry_st[l] = (({1'b0, ry_reg[l]} + {1'b0, m_reg[l]}) >= {1'b0, den[l]})
                       ? ry_reg[l] + m_reg[l] - den[l] : ry_reg[l] + m_reg[l];
        end
        col_b  = lsb_reg[1] ? (rdata[3:0] & NIBBLE_MASK) : (rdata[7:4] & NIBBLE_MASK);
        hit    = msk[0][col_a_reg] && msk[1][col_b];
        x_more = (sx_reg + PIX_W'(1)) < cmd_reg.xe;
        y_more = (sy_reg + PIX_W'(1)) < cmd_reg.ye;
        last   = !x_more && !y_more;
        empty  = (cmd_reg.xs >= cmd_reg.xe) || (cmd_reg.ys >= cmd_reg.ye);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:      if (q_valid && out_free && q_cmd.kind == CMD_QUERY)
                              state_next = BK_DIV_START;
            BK_DIV_START: state_next = BK_DIV_RUN;
            BK_DIV_RUN:   if (div_done)
                              state_next = (sel_reg == 3'd5) ? BK_SETUP : BK_DIV_START;
            BK_SETUP:     state_next = empty ? BK_DONE : BK_PIX;
            BK_PIX:       if (in_box[0] && in_box[1]) state_next = BK_RDA;
                          else if (last) state_next = BK_DONE;
            BK_RDA:       state_next = BK_RDB;
            BK_RDB:       state_next = BK_CHK;
            BK_CHK:       state_next = (hit || last) ? BK_DONE : BK_PIX;
            BK_DONE:      if (out_free) state_next = BK_IDLE;
            default:      state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop     = (state_reg == BK_IDLE) && q_valid && out_free;
        ram_we    = q_pop && (q_cmd.kind == CMD_BMWRITE);
        div_start = (state_reg == BK_DIV_START);
        out_load  = (q_pop && q_cmd.kind != CMD_QUERY)
                    || ((state_reg == BK_DONE) && out_free);
        if (state_reg == BK_DONE) begin
            out_data = '{status: ST_OK, box_hit: 1'b1, pixel_hit: hit_reg};
        end else begin
            out_data = '{status: q_cmd.status, box_hit: q_cmd.box_hit, pixel_hit: 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
        if (out_load) begin
            md_reg <= out_data;
        end
        if (q_pop) begin
            cmd_reg <= q_cmd;
            sel_reg <= '0;
        end
        case (state_reg)
            BK_DIV_RUN: begin
                if (div_done) begin
                    sel_reg <= sel_reg + 3'd1;
                    case (sel_reg)
                        3'd0: begin k_reg[0] <= div_quo[4:0]; m_reg[0] <= div_rem; end
                        3'd1: begin qx0_reg[0] <= div_quo; rx0_reg[0] <= div_rem; end
                        3'd2: begin qy_reg[0] <= div_quo; ry_reg[0] <= div_rem; end
                        3'd3: begin k_reg[1] <= div_quo[4:0]; m_reg[1] <= div_rem; end
                        3'd4: begin qx0_reg[1] <= div_quo; rx0_reg[1] <= div_rem; end
                        default: begin qy_reg[1] <= div_quo; ry_reg[1] <= div_rem; end
                    endcase
                end
            end
            BK_SETUP: begin
                sx_reg  <= cmd_reg.xs;
                sy_reg  <= cmd_reg.ys;
                hit_reg <= 1'b0;
                for (int l = 0; l < 2; l++) begin
                    qx_reg[l] <= qx0_reg[l];
                    rx_reg[l] <= rx0_reg[l];
                end
            end
            BK_RDB: begin
                col_a_reg <= lsb_reg[0] ? (rdata[3:0] & NIBBLE_MASK)
                                        : (rdata[7:4] & NIBBLE_MASK);
            end
            default: ;
        endcase
        if (state_reg == BK_PIX) begin
            for (int l = 0; l < 2; l++) begin
                addr_reg[l] <= addr_c[l];
                lsb_reg[l]  <= tx[l][0];
            end
        end
        if (state_reg == BK_CHK && hit) begin
            hit_reg <= 1'b1;
        end
        // advance to the next screen pixel, row by row
        if ((state_reg == BK_PIX && !(in_box[0] && in_box[1]))
            || (state_reg == BK_CHK && !hit)) begin
            if (x_more) begin
                sx_reg <= sx_reg + PIX_W'(1);
                for (int l = 0; l < 2; l++) begin
                    qx_reg[l] <= qx_st[l];
                    rx_reg[l] <= rx_st[l];
                end
            end else begin
                sx_reg <= cmd_reg.xs;
                sy_reg <= sy_reg + PIX_W'(1);
                for (int l = 0; l < 2; l++) begin
                    qx_reg[l] <= qx0_reg[l];
                    rx_reg[l] <= rx0_reg[l];
                    qy_reg[l] <= qy_st[l];
                    ry_reg[l] <= ry_st[l];
                end
            end
        end
    end

    assign m_valid = mv_reg;
    assign m_data  = md_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) div_done |-> state_reg == BK_DIV_RUN)
        else $error("divider finished outside a division step");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_CHK |-> $past(state_reg) == BK_RDB)
        else $error("pixel check without both bitmap reads");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_DONE && out_free) |=> (mv_reg && md_reg.box_hit))
        else $error("query result not delivered");
endmodule

// ===== src/sprite_pixel_collision.sv =====
// sprite_pixel_collision: top level of the pixel-accurate sprite collision block
// depends on spcol_pkg, spcol_front, spcol_queue, spcol_back
//
// The block keeps a table of sprites (position 12.4, scale 4.4, colour mask,
// enable and bitmap flags) and a 4-bit-per-pixel bitmap store. A transaction
// writes a bitmap byte, writes a sprite's attributes, or queries a pair; each
// gives exactly one result. The front end takes a new transaction only after
// it has queued the last one; it reads both sprites from duplicated attribute
// tables and queues a command. The back end drains that queue on its own, so
// the front keeps accepting while a result waits on m_ready, until the queue
// is full. Writes and refused or box-miss queries load their result when the
// back end pops them. A query whose boxes overlap first runs six floor
// divisions (16/scale and the starting local pixel for x and y of each sprite)
// on one shared bit-serial divider, then walks the overlap one screen pixel
// per step with add and compare updates: a pixel outside either bitmap takes
// only the PIX step, a pixel inside both takes PIX, RDA, RDB and CHK, since
// the single read port of the bitmap memory is used twice per pixel. The
// overlap is counted in screen pixels, so the scan grows with scale: two
// sprites at the largest scale are about 1020 by 1020 screen pixels each.
// The scan stops at the first hit.
// No clearing pass is needed after reset.
module sprite_pixel_collision
    import spcol_pkg::*;
#(
    parameter int SPRITE_COUNT = SPRITE_COUNT_DEF,
    parameter int SPRITE_W     = SPRITE_W_DEF,
    parameter int SPRITE_H     = SPRITE_H_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  item_t   s_data,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);
    qctl_t q_ctl;
    logic  q_ready, q_valid, q_pop;
    cmd_t  q_in, q_out;

    // front end: accept and classify each transaction
    spcol_front #(.SPRITE_COUNT(SPRITE_COUNT), .SPRITE_W(SPRITE_W), .SPRITE_H(SPRITE_H))
    u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .q_ctl(q_ctl), .q_ready(q_ready), .q_cmd(q_in));

    // command queue decouples the two ends
    spcol_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .in_ctl_i(q_ctl), .in_ready(q_ready),
        .in_cmd(q_in), .pop(q_pop), .out_valid(q_valid), .out_cmd(q_out));

    // back end: bitmap writes, overlap scan, result register
    spcol_back #(.SPRITE_COUNT(SPRITE_COUNT), .SPRITE_W(SPRITE_W), .SPRITE_H(SPRITE_H))
    u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_cmd(q_out),
        .q_pop(q_pop), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data));
endmodule
